>>> rtl/length_prefixed_frame_splitter_top_macros.svh
// assertion helpers used by lpfs_parser
`ifndef LENGTH_PREFIXED_FRAME_SPLITTER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_SPLITTER_TOP_MACROS_SVH

// property must hold at every clock edge outside reset
`define LPFS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("lpfs assertion failed");

// condition must never be true outside reset
`define LPFS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("lpfs forbidden condition seen");

`endif

>>> rtl/lpfs_pkg.sv
package lpfs_pkg;

  // number of bytes in the length prefix
  localparam int unsigned PrefixBytes = 4;
  localparam int unsigned LenWidth    = 31;
  localparam int unsigned ByteWidth   = 8;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // one result item
  typedef struct packed {
    kind_e                 kind;
    logic [ByteWidth-1:0]  payload;
    logic                  first_of_frame;
    logic                  last_of_frame;
    logic [LenWidth-1:0]   frame_length;
  } res_t;

endpackage

>>> rtl/lpfs_in_reg.sv
module lpfs_in_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lpfs_pkg::ByteWidth-1:0] in_byte_i,
  input  logic                          advance_i,
  output logic                          held_valid_o,
  output logic [lpfs_pkg::ByteWidth-1:0] held_byte_o
);

  logic                           valid_q, valid_d;
  logic [lpfs_pkg::ByteWidth-1:0] byte_q;

  // free when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // byte register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

endmodule

>>> rtl/lpfs_parser.sv
`include "length_prefixed_frame_splitter_top_macros.svh"

module lpfs_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lpfs_pkg::ByteWidth-1:0] byte_i,
  input  logic                          advance_i,
  output logic                          res_valid_o,
  output lpfs_pkg::res_t                res_o
);

  typedef enum logic [1:0] {
    PH_LEN = 2'd0,
    PH_PAY = 2'd1,
    PH_ERR = 2'd2
  } phase_e;

  localparam int unsigned SeenWidth = $clog2(lpfs_pkg::PrefixBytes);
  localparam int unsigned AccWidth  = lpfs_pkg::PrefixBytes * lpfs_pkg::ByteWidth;

  phase_e                          phase_q, phase_d;
  logic [SeenWidth-1:0]            seen_q, seen_d;
  logic [AccWidth-1:0]             acc_q, acc_d;
  logic [lpfs_pkg::LenWidth-1:0]   rem_q, rem_d;
  logic [AccWidth-1:0]             acc_shift;
  logic [lpfs_pkg::LenWidth-1:0]   cur_len;
  logic                            pay_last;

  assign acc_shift = {acc_q[AccWidth-lpfs_pkg::ByteWidth-1:0], byte_i};
  assign cur_len   = acc_q[lpfs_pkg::LenWidth-1:0];
  assign pay_last  = (rem_q <= lpfs_pkg::LenWidth'(1));

  // next state and result for the held byte
  always_comb begin
    phase_d     = phase_q;
    seen_d      = seen_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: lpfs_pkg::KIND_PAYLOAD, payload: '0, first_of_frame: 1'b0,
                    last_of_frame: 1'b0, frame_length: '0};
    case (phase_q)
      PH_LEN: begin
        acc_d  = acc_shift;
        seen_d = seen_q + SeenWidth'(1);
        if (seen_q == SeenWidth'(lpfs_pkg::PrefixBytes - 1)) begin
          seen_d = '0;
          if (acc_shift[AccWidth-1]) begin
            // negative length: report and lock up
            phase_d     = PH_ERR;
            acc_d       = '0;
            rem_d       = '0;
            res_valid_o = 1'b1;
            res_o.kind  = lpfs_pkg::KIND_ERROR;
          end else if (acc_shift == '0) begin
            // empty frame
            res_valid_o         = 1'b1;
            res_o.kind          = lpfs_pkg::KIND_EMPTY;
            res_o.last_of_frame = 1'b1;
          end else begin
            rem_d   = acc_shift[lpfs_pkg::LenWidth-1:0];
            phase_d = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        res_valid_o          = 1'b1;
        res_o.kind           = lpfs_pkg::KIND_PAYLOAD;
        res_o.payload        = byte_i;
        res_o.first_of_frame = (rem_q == cur_len);
        res_o.last_of_frame  = pay_last;
        res_o.frame_length   = cur_len;
        if (pay_last) begin
          rem_d   = '0;
          acc_d   = '0;
          phase_d = PH_LEN;
        end else begin
          rem_d = rem_q - lpfs_pkg::LenWidth'(1);
        end
      end
      default: begin
        // sticky error: drop the item
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      seen_q  <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      seen_q  <= seen_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
    end
  end

  // prefix count only moves while gathering a length
  `LPFS_ASSERT(a_seen_idle, clk_i, rst_ni, (phase_q != PH_LEN) |-> (seen_q == '0))
  // error phase is never left
  `LPFS_ASSERT(a_err_sticky, clk_i, rst_ni, (phase_q == PH_ERR) |=> (phase_q == PH_ERR))
  // countdown stays within the frame length
  `LPFS_ASSERT(a_rem_range, clk_i, rst_ni,
    (phase_q == PH_PAY) |-> (rem_q != '0 && rem_q <= cur_len))
  // nothing is produced in the error phase
  `LPFS_ASSERT_NEVER(a_err_silent, clk_i, rst_ni, (phase_q == PH_ERR) && res_valid_o)

endmodule

>>> rtl/lpfs_out_reg.sv
module lpfs_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  lpfs_pkg::res_t res_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lpfs_pkg::res_t res_o
);

  logic           valid_q, valid_d;
  lpfs_pkg::res_t res_q;

  // register can take a new item when empty or being drained
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/length_prefixed_frame_splitter_top.sv
// Splits a byte stream framed by 4-byte big-endian signed length prefixes.
// Each input item is one byte; prefix bytes give no result, each payload byte
// gives one result (kind payload) flagged first/last, a zero length gives one
// empty-frame result, and a negative length gives one error result after
// which every byte is dropped until reset. One byte is taken every clock while
// the output is not stalled: a byte is held in the input register, is parsed
// combinationally by the length counter and countdown, and its result is
// loaded into the output register. Both registers hold while the output is
// stalled.
module length_prefixed_frame_splitter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] payload, [38:8] frame_length, [39] zero
  output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] first_of_frame
  output logic        m_axis_tlast    // last_of_frame
);

  logic                           held_valid;
  logic [lpfs_pkg::ByteWidth-1:0] held_byte;
  logic                           out_free;
  logic                           advance;
  logic                           res_valid;
  lpfs_pkg::res_t                 res;
  lpfs_pkg::res_t                 out_res;

  // held item moves on when the result register can take it
  assign advance = held_valid && out_free;

  lpfs_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte)
  );

  lpfs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (held_byte),
    .advance_i   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpfs_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  // pack result fields onto the stream
  assign m_axis_tdata = {1'b0, out_res.frame_length, out_res.payload};
  assign m_axis_tuser = {out_res.first_of_frame, out_res.kind};
  assign m_axis_tlast = out_res.last_of_frame;

endmodule
